@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL of the framebuffer pixel unpacker.
// Needs nothing else; files that assert take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/fbpu_pkg.sv @@
// Package for the framebuffer pixel unpacker: payload and configuration types,
// register indexes, reset values and the channel extraction function. No dependencies.
package fbpu_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int WORD_BITS     = 32;
    localparam int PARTIAL_BITS  = 24;
    localparam int FMT_BITS      = 9;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = FMT_BITS;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [2:0] BYTES_16BPP = 3'd2;
    localparam logic [2:0] BYTES_32BPP = 3'd4;
    localparam logic [3:0] LEN_MAX     = 4'd8;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PIXEL_MODE   = 3'd0,
        REG_RED_FORMAT   = 3'd1,
        REG_GREEN_FORMAT = 3'd2,
        REG_BLUE_FORMAT  = 3'd3,
        REG_ALPHA_FORMAT = 3'd4
    } cfg_reg_idx_t;

    localparam logic                PIXEL_MODE_RESET   = 1'b1;
    localparam logic [FMT_BITS-1:0] RED_FORMAT_RESET   = 9'd272;
    localparam logic [FMT_BITS-1:0] GREEN_FORMAT_RESET = 9'd264;
    localparam logic [FMT_BITS-1:0] BLUE_FORMAT_RESET  = 9'd256;
    localparam logic [FMT_BITS-1:0] ALPHA_FORMAT_RESET = 9'd280;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       image_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } out_item_t;

    typedef struct packed {
        logic                pixel_mode;
        logic [FMT_BITS-1:0] red_format;
        logic [FMT_BITS-1:0] green_format;
        logic [FMT_BITS-1:0] blue_format;
        logic [FMT_BITS-1:0] alpha_format;
    } fbpu_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fbpu_q_status_t;

    // Field length with anything above eight treated as eight.
    function automatic logic [3:0] fmt_length(logic [FMT_BITS-1:0] fmt);
        logic [3:0] len;
        len = fmt[8:5];
        return (len > LEN_MAX) ? LEN_MAX : len;
    endfunction

    // Takes the field at the format's offset and length and moves its top bit to bit 7.
    function automatic logic [7:0] extract_channel(logic [WORD_BITS-1:0] word,
                                                   logic [FMT_BITS-1:0] fmt);
        logic [3:0]           len;
        logic [3:0]           pad;
        logic [WORD_BITS-1:0] shifted;
        logic [7:0]           mask;
        len     = fmt_length(fmt);
        pad     = LEN_MAX - len;
        shifted = word >> fmt[4:0];
        mask    = 8'hFF >> pad;
        return (shifted[7:0] & mask) << pad;
    endfunction

endpackage

@@ hdl/framebuffer_pixel_unpack_core.sv @@
// Top level of the framebuffer pixel unpacker: configuration registers and the
// gather, queue and unpack stages. Depends on fbpu_pkg and assert_macros.svh.
//
//   Channel  | Handshake        | Payload                    | Transfer when
//   ---------+------------------+----------------------------+-------------------
//   input    | push / full      | pixel_in  (in_item_t)      | push && !full
//   result   | pop / empty      | pixel_out (out_item_t)     | pop && !empty
//   config   | write_enable     | reg_index, write_data      | write_enable
//
// The block takes one byte every clock cycle while full is low. A byte that
// completes a pixel is written into the word queue at that edge and is then
// loaded into the result register when it is free or being drained; bytes that
// do not complete a pixel give nothing. full rises only when the word queue is
// full, which needs the result side to have stalled for several pixels. Reset
// clears the byte position, the partial word, the queue pointers and the result
// valid flag, and loads the register reset values (32 bpp, red at bit 16, green
// at bit 8, blue at bit 0, alpha at bit 24, all eight bits wide).
`include "assert_macros.svh"

module framebuffer_pixel_unpack_core #(
    parameter int QUEUE_DEPTH = fbpu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  fbpu_pkg::in_item_t                pixel_in,
    output logic                              empty,
    input  logic                              pop,
    output fbpu_pkg::out_item_t               pixel_out,
    input  logic                              write_enable,
    input  logic [fbpu_pkg::CFG_INDEX_W-1:0]  reg_index,
    input  logic [fbpu_pkg::CFG_DATA_W-1:0]   write_data
);
    import fbpu_pkg::*;

    fbpu_cfg_t            cfg_reg, cfg_next;
    fbpu_q_status_t       q_status;
    logic                 in_take;
    logic                 q_push;
    logic                 q_pop;
    logic [WORD_BITS-1:0] q_push_word;
    logic [WORD_BITS-1:0] q_head_word;
    logic                 start_in_32bpp;

    // Configuration writes. The user must change the registers only while the block
    // is idle, unenforced; stages read them directly. Indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            case (reg_index)
                REG_PIXEL_MODE:   cfg_next.pixel_mode   = write_data[0];
                REG_RED_FORMAT:   cfg_next.red_format   = write_data[FMT_BITS-1:0];
                REG_GREEN_FORMAT: cfg_next.green_format = write_data[FMT_BITS-1:0];
                REG_BLUE_FORMAT:  cfg_next.blue_format  = write_data[FMT_BITS-1:0];
                REG_ALPHA_FORMAT: cfg_next.alpha_format = write_data[FMT_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_mode   <= PIXEL_MODE_RESET;
            cfg_reg.red_format   <= RED_FORMAT_RESET;
            cfg_reg.green_format <= GREEN_FORMAT_RESET;
            cfg_reg.blue_format  <= BLUE_FORMAT_RESET;
            cfg_reg.alpha_format <= ALPHA_FORMAT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The input side stalls only on a full word queue, so a byte that does
    // not complete a pixel is never held back by the result side directly.
    assign full    = q_status.full;
    assign in_take = push && !full;

    assign start_in_32bpp = in_take && pixel_in.image_start && cfg_reg.pixel_mode;

    fbpu_gather u_gather (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_take),
        .item       (pixel_in),
        .pixel_mode (cfg_reg.pixel_mode),
        .word_push  (q_push),
        .word       (q_push_word)
    );

    fbpu_word_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_word_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (q_push),
        .push_word (q_push_word),
        .pop_en    (q_pop),
        .head_word (q_head_word),
        .status    (q_status)
    );

    fbpu_channel_unpack u_channel_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .head_word (q_head_word),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .pixel_out (pixel_out)
    );

    // A start byte in 32 bpp mode is byte 0 of four and can never finish a pixel.
    `ASSERT_IMPLIES(a_start_no_pixel, clk, rst_n, start_in_32bpp, !q_push)
    // The unpack stage only takes a word that the queue holds.
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, !q_status.empty)
    // A waiting word reaches the result register as soon as it is free or drained.
    `ASSERT_NEXT(a_result_loads, clk, rst_n, !q_status.empty && (empty || pop), !empty)

endmodule

@@ hdl/fbpu_gather.sv @@
// Front part of the unpacker: collects bytes into a pixel word and flags a completed pixel.
// Depends on fbpu_pkg.
module fbpu_gather (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  fbpu_pkg::in_item_t              item,
    input  logic                            pixel_mode,
    output logic                            word_push,
    output logic [fbpu_pkg::WORD_BITS-1:0]  word
);
    import fbpu_pkg::*;

    logic [1:0]              pos_reg, pos_next;
    logic [PARTIAL_BITS-1:0] partial_reg, partial_next;

    logic [1:0]              pos;
    logic [PARTIAL_BITS-1:0] partial;
    logic [WORD_BITS-1:0]    merged;
    logic [2:0]              byte_count;
    logic                    complete;

    always_comb
    begin
        // A start byte always lands in byte 0 and drops whatever was gathered.
        pos        = item.image_start ? 2'd0 : pos_reg;
        partial    = item.image_start ? '0 : partial_reg;
        merged     = {8'd0, partial} | ({24'd0, item.pixel_byte} << {pos, 3'b000});
        byte_count = pixel_mode ? BYTES_32BPP : BYTES_16BPP;
        complete   = ({1'b0, pos} + 3'd1) >= byte_count;

        pos_next     = pos_reg;
        partial_next = partial_reg;
        if (take)
        begin
            if (complete)
            begin
                pos_next     = 2'd0;
                partial_next = '0;
            end
            else
            begin
                pos_next     = pos + 2'd1;
                partial_next = merged[PARTIAL_BITS-1:0];
            end
        end

        word_push = take && complete;
        word      = pixel_mode ? merged : {16'd0, merged[15:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 2'd0;
            partial_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            partial_reg <= partial_next;
        end
    end

endmodule

@@ hdl/fbpu_word_queue.sv @@
// Short queue of completed pixel words between the gather and unpack stages.
// Depends on fbpu_pkg.
module fbpu_word_queue #(
    parameter int DEPTH = fbpu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push_en,
    input  logic [fbpu_pkg::WORD_BITS-1:0]  push_word,
    input  logic                            pop_en,
    output logic [fbpu_pkg::WORD_BITS-1:0]  head_word,
    output fbpu_pkg::fbpu_q_status_t        status
);
    import fbpu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WORD_BITS-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    always_comb
    begin
        status.full  = (count_reg == CNT_W'(DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push_en && !status.full;
        do_pop       = pop_en && !status.empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;

        head_word = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/fbpu_channel_unpack.sv @@
// Back part of the unpacker: cuts the four channel fields out of a pixel word
// into the registered result, alpha opaque if zero-length. Depends on fbpu_pkg.
module fbpu_channel_unpack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbpu_pkg::fbpu_cfg_t             cfg,
    input  fbpu_pkg::fbpu_q_status_t        q_status,
    input  logic [fbpu_pkg::WORD_BITS-1:0]  head_word,
    output logic                            q_pop,
    input  logic                            pop,
    output logic                            empty,
    output fbpu_pkg::out_item_t             pixel_out
);
    import fbpu_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t pixel_reg, pixel_next;

    always_comb
    begin
        // A waiting word loads the result register when it is free or drained.
        q_pop      = !q_status.empty && (!valid_reg || pop);
        valid_next = q_pop || (valid_reg && !pop);

        pixel_next.alpha_out = (fmt_length(cfg.alpha_format) == 4'd0)
                             ? ALPHA_OPAQUE : extract_channel(head_word, cfg.alpha_format);
        pixel_next.red_out   = extract_channel(head_word, cfg.red_format);
        pixel_next.green_out = extract_channel(head_word, cfg.green_format);
        pixel_next.blue_out  = extract_channel(head_word, cfg.blue_format);

        empty     = !valid_reg;
        pixel_out = pixel_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            pixel_reg <= pixel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for framebuffer_pixel_unpack_core: drives raw bytes, predicts
// each ARGB8888 pixel and checks every result transfer. Depends on fbpu_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    import fbpu_pkg::*;

    // Cycles without any transfer or register write before the run is declared hung.
    // The longest legal quiet stretch is the deliberate result hold-off.
    localparam int HANG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    in_item_t               pixel_in;
    logic                   empty;
    logic                   pop;
    out_item_t              pixel_out;
    logic                   write_enable;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  write_data;

    framebuffer_pixel_unpack_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_in     (pixel_in),
        .empty        (empty),
        .pop          (pop),
        .pixel_out    (pixel_out),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    // Predictor state: the gathering position and partial word, and a shadow of
    // the configuration registers as the block should hold them.
    logic [1:0]  gather_pos;
    logic [23:0] gather_word;
    fbpu_cfg_t   shadow_cfg;

    // Pixels that the predictor has produced and the block has not yet delivered.
    out_item_t   pending_pixels[$];

    int          mismatches;
    int          byte_transfers;
    int          pixels_checked;
    int          reg_writes;
    int          full_stall_cycles;
    int          quiet_cycles;
    int          result_hold_cycles;
    bit          quiet_phase;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Builds a format register value from a field length and a bit offset.
    function automatic logic [FMT_BITS-1:0] field_fmt(int len, int off);
        return {len[3:0], off[4:0]};
    endfunction

    // Cuts the field out of the pixel word and scales it so that its top bit
    // lands on bit 7. Lengths above eight behave as eight; zero gives zero.
    function automatic logic [7:0] scale_field(logic [31:0] word, logic [FMT_BITS-1:0] fmt);
        int          width;
        logic [31:0] field;
        width = int'(fmt[8:5]);
        if (width > CHANNEL_BITS)
            width = CHANNEL_BITS;
        if (width == 0)
            return 8'h00;
        field = (word >> fmt[4:0]) & ((32'd1 << width) - 32'd1);
        field = field << (CHANNEL_BITS - width);
        return field[7:0];
    endfunction

    // Takes one accepted byte into the gathering state. When the byte completes
    // a pixel, the expected ARGB value is queued.
    function automatic void absorb_byte(in_item_t item);
        logic [31:0] word;
        int          need;
        out_item_t   px;
        if (item.image_start)
        begin
            gather_pos  = 2'd0;
            gather_word = 24'd0;
        end
        word = {8'h00, gather_word} | (32'(item.pixel_byte) << (8 * gather_pos));
        need = shadow_cfg.pixel_mode ? int'(BYTES_32BPP) : int'(BYTES_16BPP);
        if (int'(gather_pos) + 1 < need)
        begin
            gather_word = word[23:0];
            gather_pos  = gather_pos + 2'd1;
            return;
        end
        // In 16 bpp mode anything gathered above the low two bytes is dropped,
        // which matters when the mode was changed part-way through a pixel.
        if (!shadow_cfg.pixel_mode)
            word[31:16] = 16'h0000;
        gather_pos  = 2'd0;
        gather_word = 24'd0;
        px.alpha_out = (shadow_cfg.alpha_format[8:5] == 4'd0) ? ALPHA_OPAQUE :
                       scale_field(word, shadow_cfg.alpha_format);
        px.red_out   = scale_field(word, shadow_cfg.red_format);
        px.green_out = scale_field(word, shadow_cfg.green_format);
        px.blue_out  = scale_field(word, shadow_cfg.blue_format);
        pending_pixels.push_back(px);
    endfunction

    // ------------------------------------------------------------------
    // Monitors: input transfers feed the predictor, result transfers are
    // compared against the oldest pending pixel, and a watchdog guards
    // against a hung block.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            absorb_byte(pixel_in);
            byte_transfers++;
        end
        if (rst_n && push && full)
            full_stall_cycles++;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected pixel: a=%02h r=%02h g=%02h b=%02h",
                             pixel_out.alpha_out, pixel_out.red_out,
                             pixel_out.green_out, pixel_out.blue_out);
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (pixel_out.alpha_out !== want.alpha_out ||
                    pixel_out.red_out   !== want.red_out   ||
                    pixel_out.green_out !== want.green_out ||
                    pixel_out.blue_out  !== want.blue_out)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Pixel mismatch: expected a=%02h r=%02h g=%02h b=%02h, %s",
                                 want.alpha_out, want.red_out, want.green_out,
                                 want.blue_out,
                                 $sformatf("got a=%02h r=%02h g=%02h b=%02h",
                                           pixel_out.alpha_out, pixel_out.red_out,
                                           pixel_out.green_out, pixel_out.blue_out));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || write_enable)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles, %0d pixels still pending",
                     quiet_cycles, pending_pixels.size());
            $display("FAIL framebuffer_pixel_unpack_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: pop is driven in random bursts. A test may ask for one
    // long hold-off, which is counted out here in this process.
    // ------------------------------------------------------------------

    initial
    begin
        int span;
        pop = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (result_hold_cycles > 0)
            begin
                span = result_hold_cycles;
                result_hold_cycles = 0;
                pop <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side helpers. Every task is entered just after a rising edge
    // and leaves just after one. send_byte leaves push high, so the caller
    // either sends again or lowers push through sender_pause or
    // settle_results; push is never lowered and raised in the same step.
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] value, input logic start);
        push     <= 1'b1;
        pixel_in <= in_item_t'{pixel_byte: value, image_start: start};
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic sender_pause(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits until every predicted pixel has been delivered, then lets the
    // pipeline run dry before any register is touched. The first edge gives
    // the input monitor time to take in the last byte that was sent.
    task automatic settle_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= value;
        @(posedge clk);
        case (idx)
            REG_PIXEL_MODE:   shadow_cfg.pixel_mode   = value[0];
            REG_RED_FORMAT:   shadow_cfg.red_format   = value;
            REG_GREEN_FORMAT: shadow_cfg.green_format = value;
            REG_BLUE_FORMAT:  shadow_cfg.blue_format  = value;
            REG_ALPHA_FORMAT: shadow_cfg.alpha_format = value;
            default: ;
        endcase
        reg_writes++;
        write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic mode, input logic [FMT_BITS-1:0] red,
                             input logic [FMT_BITS-1:0] green,
                             input logic [FMT_BITS-1:0] blue,
                             input logic [FMT_BITS-1:0] alpha);
        write_reg(REG_PIXEL_MODE, {8'h00, mode});
        write_reg(REG_RED_FORMAT, red);
        write_reg(REG_GREEN_FORMAT, green);
        write_reg(REG_BLUE_FORMAT, blue);
        write_reg(REG_ALPHA_FORMAT, alpha);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly lengths of one to eight; now and then zero or an over-long one,
    // and offsets that often fall inside the word but sometimes run past it.
    function automatic logic [FMT_BITS-1:0] random_format();
        int len;
        int off;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default:
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
                off = $urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(0, 31);
                return field_fmt(len, off);
            end
        endcase
    endfunction

    task automatic maybe_gap();
        if (!quiet_phase && $urandom_range(0, 7) == 0)
            sender_pause($urandom_range(1, 12));
    endtask

    // Sends roughly the given number of bytes. Most are whole images that open
    // with a start flag and carry whole pixels; the rest are short bursts with
    // stray start flags that cut pixels short.
    task automatic send_images(input int count);
        int sent;
        int pixels;
        int per_pixel;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                per_pixel = shadow_cfg.pixel_mode ? int'(BYTES_32BPP) : int'(BYTES_16BPP);
                pixels    = $urandom_range(1, 6);
                for (int i = 0; i < pixels * per_pixel; i++)
                begin
                    maybe_gap();
                    send_byte(random_byte(), i == 0);
                    sent++;
                end
            end
            else
            begin
                burst = $urandom_range(1, 5);
                for (int i = 0; i < burst; i++)
                begin
                    maybe_gap();
                    send_byte(random_byte(), $urandom_range(0, 2) == 0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 32 bpp with the usual ARGB byte lanes.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // RGB565 with no alpha field, then the format corners: a zero-length
    // colour, over-long lengths at the top offset, and a field beyond the
    // 16-bit word.
    task automatic test_format_corners();
        settle_results();
        write_all(1'b0, field_fmt(5, 11), field_fmt(6, 5), field_fmt(5, 0), field_fmt(0, 0));
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hF8, 1'b0);
        settle_results();
        write_all(1'b0, '0, '1, field_fmt(8, 16), '1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // A start flag in the middle of a pixel throws away the bytes before it.
    task automatic test_start_realign();
        settle_results();
        write_all(PIXEL_MODE_RESET, RED_FORMAT_RESET, GREEN_FORMAT_RESET,
                  BLUE_FORMAT_RESET, ALPHA_FORMAT_RESET);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b0);
        send_byte(8'h77, 1'b0);
    endtask

    // Mode changes with a pixel half gathered: dropping to 16 bpp after three
    // bytes completes on the next byte, and going up to 32 bpp after one byte
    // needs three more.
    task automatic test_mode_switch();
        send_byte(8'hAB, 1'b1);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hEF, 1'b0);
        settle_results();
        write_reg(REG_PIXEL_MODE, 9'd0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        settle_results();
        write_reg(REG_PIXEL_MODE, 9'd1);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0);
    endtask

    // Phases of random traffic, each under a fresh register setting. The first
    // two phases take the all-zero and all-ones extremes of every register.
    task automatic test_random_formats();
        for (int phase = 0; phase < 12; phase++)
        begin
            settle_results();
            if (phase == 0)
                write_all(1'b0, '0, '0, '0, '0);
            else if (phase == 1)
            begin
                write_reg(REG_PIXEL_MODE, '1);
                write_reg(REG_RED_FORMAT, '1);
                write_reg(REG_GREEN_FORMAT, '1);
                write_reg(REG_BLUE_FORMAT, '1);
                write_reg(REG_ALPHA_FORMAT, '1);
            end
            else
            begin
                // Upper data bits of the mode register are junk and must be ignored.
                write_reg(REG_PIXEL_MODE, 9'($urandom_range(0, 511)));
                if ($urandom_range(0, 3) != 0) write_reg(REG_RED_FORMAT, random_format());
                if ($urandom_range(0, 3) != 0) write_reg(REG_GREEN_FORMAT, random_format());
                if ($urandom_range(0, 3) != 0) write_reg(REG_BLUE_FORMAT, random_format());
                if ($urandom_range(0, 3) != 0) write_reg(REG_ALPHA_FORMAT, random_format());
            end
            send_images(110);
        end
    endtask

    // The result side holds off for a long stretch while bytes keep coming,
    // so the word queue fills and full must stall the input. Afterwards the
    // sender waits for every pixel to come out.
    task automatic test_backpressure();
        settle_results();
        write_all(1'b0, field_fmt(5, 11), field_fmt(6, 5), field_fmt(5, 0), field_fmt(0, 0));
        result_hold_cycles = 300;
        for (int i = 0; i < 120; i++)
            send_byte(random_byte(), i == 0);
        settle_results();
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_unbroken_stream();
        settle_results();
        write_all(1'b1, random_format(), random_format(), random_format(), random_format());
        quiet_phase = 1'b1;
        send_images(160);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        shadow_cfg.pixel_mode   = PIXEL_MODE_RESET;
        shadow_cfg.red_format   = RED_FORMAT_RESET;
        shadow_cfg.green_format = GREEN_FORMAT_RESET;
        shadow_cfg.blue_format  = BLUE_FORMAT_RESET;
        shadow_cfg.alpha_format = ALPHA_FORMAT_RESET;
        gather_pos         = 2'd0;
        gather_word        = 24'd0;
        mismatches         = 0;
        byte_transfers     = 0;
        pixels_checked     = 0;
        reg_writes         = 0;
        full_stall_cycles  = 0;
        quiet_cycles       = 0;
        result_hold_cycles = 0;
        quiet_phase        = 1'b0;
        push         = 1'b0;
        pixel_in     = '0;
        write_enable = 1'b0;
        reg_index    = REG_PIXEL_MODE;
        write_data   = '0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_format_corners();
        test_start_realign();
        test_mode_switch();
        test_random_formats();
        test_backpressure();
        test_unbroken_stream();

        settle_results();
        repeat (8) @(posedge clk);
        mismatches += pending_pixels.size();

        $display("Run covered %0d byte transfers, %0d checked pixels and %0d register writes;",
                 byte_transfers, pixels_checked, reg_writes);
        $display("the input was held off by a full queue for %0d cycles, with %0d mismatches.",
                 full_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("PASS framebuffer_pixel_unpack_core");
        else
            $display("FAIL framebuffer_pixel_unpack_core");
        $finish;
    end

endmodule
